FILE: rtl/sab_pkg.sv
// Shared command and status types for the suffix automaton builder.
`timescale 1ns / 1ps
package sab_pkg;

  // Commands from the sequencer to the datapath, one flag per action.
  typedef struct packed {
    logic init_root;
    logic start;
    logic out_bad;
    logic out_ovf;
    logic out_done;
    logic step_link;
    logic wr_entry_t;
    logic wr_entry_nq;
    logic take_q;
    logic alloc_t;
    logic new_t;
    logic set_lk_q;
    logic lk_root;
    logic alloc_nq;
    logic clone_row;
    logic clone_fix;
  } sab_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic sym_bad;
    logic entry_zero;
    logic entry_eq_q;
    logic link_zero;
    logic len_match;
    logic full1;
    logic full2;
    logic out_valid;
  } sab_status_t;

endpackage

FILE: rtl/suffix_automaton_builder_core.sv
// Top level of the suffix automaton builder: sequencer, datapath and stream ports.
`timescale 1ns / 1ps
// Each input word appends one symbol to the string seen since reset and yields
// one result word: the new state for the whole prefix, its length, its suffix
// link, and the clone state if one was split off. A symbol outside the alphabet
// gives an all-zero word; a symbol that would overflow the state store is refused,
// leaves the automaton unchanged and returns a word with only the overflow flag.
// After reset the block writes the root entry in its init state before it takes
// its first word. A symbol is handled in two passes over its suffix links: a
// read-only pass that counts the states needed, then a pass that adds the
// missing transitions. A walk ends when it runs past the root or meets an
// existing transition. A clone adds a step that copies the row, one that fixes
// the link of the split state, and a walk that redirects transitions to the new
// clone. A refused symbol ends after the first pass; a symbol outside the
// alphabet is answered straight from idle. The transition rows and the
// link/length store each have a single registered read port and are read one
// state per cycle. Amortized over a string the link walks are short. The result
// word is registered by the step that ends the symbol. A stalled result holds
// the input off: a new word is taken only when the result register is empty or
// is being emptied at the same edge.
module suffix_automaton_builder_core #(
  parameter int STATE_COUNT   = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [symbol]
  input  logic [(($clog2(ALPHABET_SIZE)+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [new_state, prefix_length, new_link, cloned, clone_state, overflow, zero pad]
  output logic [((4*$clog2(STATE_COUNT)+2+7)/8)*8-1:0] out_tdata
);
  import sab_pkg::*;

  localparam int SW    = $clog2(STATE_COUNT);
  localparam int SYMW  = $clog2(ALPHABET_SIZE);
  localparam int OUT_W = ((4*SW+2+7)/8)*8;
  localparam int PAD_W = OUT_W - (4*SW+2);

  sab_cmd_t    cmd;
  sab_status_t st;

  logic          o_valid, o_cloned, o_ovf;
  logic [SW-1:0] o_ns, o_len, o_lk, o_cs;

  sab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  sab_dpath #(
    .STATE_COUNT   (STATE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sym            (in_tdata[SYMW-1:0]),
    .out_tready        (out_tready),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (o_valid),
    .out_new_state     (o_ns),
    .out_prefix_length (o_len),
    .out_new_link      (o_lk),
    .out_cloned        (o_cloned),
    .out_clone_state   (o_cs),
    .out_overflow      (o_ovf)
  );

  assign out_tvalid = o_valid;
  assign out_tdata  = {PAD_W'(0), o_ovf, o_cs, o_cloned, o_lk, o_len, o_ns};

  // A clone is always allocated right after the new state of the same symbol.
  a_clone_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_cloned) |-> (o_cs == o_ns + SW'(1)))
    else $error("clone index does not follow new state");

  // A refused symbol reports nothing but the overflow flag.
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_ovf) |-> (!o_cloned && o_ns == '0 && o_cs == '0))
    else $error("overflow word carries state data");

  // A new state always carries a suffix link and a length, both nonzero.
  a_link_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_ns != '0) |-> (o_lk != '0 && o_len != '0))
    else $error("new state without link or length");

endmodule

FILE: rtl/sab_ctrl.sv
// Sequencer for the suffix automaton builder: walks, clone and result steps.
`timescale 1ns / 1ps
module sab_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  input  sab_pkg::sab_status_t st,
  output sab_pkg::sab_cmd_t    cmd
);
  import sab_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CK   = 4'd2;
  localparam logic [3:0] S_CKQ  = 4'd3;
  localparam logic [3:0] S_NEW  = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_CQ2  = 4'd6;
  localparam logic [3:0] S_CL   = 4'd7;
  localparam logic [3:0] S_CL2  = 4'd8;
  localparam logic [3:0] S_W3   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && (!st.out_valid || out_tready);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_root = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (st.sym_bad) begin
            cmd.out_bad = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_CK;
          end
        end
      end
      S_CK: begin
        if (st.entry_zero) begin
          if (st.link_zero) begin
            if (st.full1) begin
              cmd.out_ovf = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.alloc_t = 1'b1;
              state_nxt   = S_NEW;
            end
          end else begin
            cmd.step_link = 1'b1;
          end
        end else begin
          cmd.take_q = 1'b1;
          state_nxt  = S_CKQ;
        end
      end
      S_CKQ: begin
        if (st.len_match ? st.full1 : st.full2) begin
          cmd.out_ovf = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.alloc_t = 1'b1;
          state_nxt   = S_NEW;
        end
      end
      S_NEW: begin
        cmd.new_t = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        if (st.entry_zero) begin
          cmd.wr_entry_t = 1'b1;
          cmd.step_link  = 1'b1;
          if (st.link_zero) begin
            cmd.lk_root = 1'b1;
            state_nxt   = S_FIN;
          end
        end else begin
          cmd.take_q = 1'b1;
          state_nxt  = S_CQ2;
        end
      end
      S_CQ2: begin
        if (st.len_match) begin
          cmd.set_lk_q = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.alloc_nq = 1'b1;
          state_nxt    = S_CL;
        end
      end
      S_CL: begin
        cmd.clone_row = 1'b1;
        state_nxt     = S_CL2;
      end
      S_CL2: begin
        cmd.clone_fix = 1'b1;
        state_nxt     = S_W3;
      end
      S_W3: begin
        if (st.entry_eq_q) begin
          cmd.wr_entry_nq = 1'b1;
          cmd.step_link   = 1'b1;
          if (st.link_zero) begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.out_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/sab_dpath.sv
// Datapath of the suffix automaton builder: tables, walk registers, result word.
`timescale 1ns / 1ps
module sab_dpath #(
  parameter int STATE_COUNT   = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(ALPHABET_SIZE)-1:0]     in_sym,
  input  logic                                 out_tready,
  input  sab_pkg::sab_cmd_t                    cmd,
  output sab_pkg::sab_status_t                 st,
  output logic                                 out_valid,
  output logic [$clog2(STATE_COUNT)-1:0]       out_new_state,
  output logic [$clog2(STATE_COUNT)-1:0]       out_prefix_length,
  output logic [$clog2(STATE_COUNT)-1:0]       out_new_link,
  output logic                                 out_cloned,
  output logic [$clog2(STATE_COUNT)-1:0]       out_clone_state,
  output logic                                 out_overflow
);
  import sab_pkg::*;

  localparam int SW   = $clog2(STATE_COUNT);
  localparam int SYMW = $clog2(ALPHABET_SIZE);
  localparam int RW   = ALPHABET_SIZE * SW;

  // Transition rows, and {suffix link, longest length} per state.
  logic [RW-1:0]   row_mem  [STATE_COUNT];
  logic [2*SW-1:0] node_mem [STATE_COUNT];

  logic [RW-1:0]   rd_row;
  logic [2*SW-1:0] rd_node;
  logic [SW-1:0]   rd_link, rd_len, entry;

  logic [SYMW-1:0] sym_r;
  logic [SW-1:0]   p_r, q_r, t_r, nq_r, lk_r, lenp_r, lent_r, linkq_r, lenq_r;
  logic [SW-1:0]   last_r, cnt_r;
  logic            out_valid_r;
  logic [SW-1:0]   o_ns_r, o_len_r, o_lk_r, o_cs_r;
  logic            o_cl_r, o_ov_r;

  logic [SW-1:0]   row_raddr, node_raddr, row_waddr, node_waddr;
  logic            row_we, node_we;
  logic [RW-1:0]   row_wdata, row_mod;
  logic [2*SW-1:0] node_wdata;
  logic [SW-1:0]   slot_val;
  logic [SW-1:0]   cnt_inc;

  assign rd_link = rd_node[2*SW-1:SW];
  assign rd_len  = rd_node[SW-1:0];
  assign entry   = rd_row[sym_r*SW +: SW];
  assign cnt_inc = cnt_r + SW'(1);

  assign st.sym_bad    = {1'b0, in_sym} >= (SYMW+1)'(ALPHABET_SIZE);
  assign st.entry_zero = (entry == '0);
  assign st.entry_eq_q = (entry == q_r);
  assign st.link_zero  = (rd_link == '0);
  assign st.len_match  = ((lenp_r + SW'(1)) == rd_len);
  assign st.full1      = ({1'b0, cnt_r} + (SW+1)'(1)) > (SW+1)'(STATE_COUNT - 1);
  assign st.full2      = ({1'b0, cnt_r} + (SW+1)'(2)) > (SW+1)'(STATE_COUNT - 1);
  assign st.out_valid  = out_valid_r;

  // Read addresses: default follows the walk pointer.
  always_comb begin
    row_raddr  = p_r;
    node_raddr = p_r;
    if (cmd.start || cmd.new_t) begin
      row_raddr  = last_r;
      node_raddr = last_r;
    end else if (cmd.alloc_t) begin
      node_raddr = last_r;
    end else if (cmd.take_q) begin
      node_raddr = entry;
    end else if (cmd.alloc_nq) begin
      row_raddr = q_r;
    end else if (cmd.step_link) begin
      row_raddr  = rd_link;
      node_raddr = rd_link;
    end
  end

  // Row with the current symbol's slot replaced.
  always_comb begin
    slot_val = cmd.wr_entry_nq ? nq_r : t_r;
    row_mod  = rd_row;
    row_mod[sym_r*SW +: SW] = slot_val;
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = p_r;
    row_wdata = row_mod;
    if (cmd.init_root) begin
      row_we    = 1'b1;
      row_waddr = SW'(1);
      row_wdata = '0;
    end else if (cmd.new_t) begin
      row_we    = 1'b1;
      row_waddr = cnt_inc;
      row_wdata = '0;
    end else if (cmd.clone_row) begin
      row_we    = 1'b1;
      row_waddr = nq_r;
      row_wdata = rd_row;
    end else if (cmd.wr_entry_t || cmd.wr_entry_nq) begin
      row_we = 1'b1;
    end
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = t_r;
    node_wdata = {lk_r, lent_r};
    if (cmd.init_root) begin
      node_we    = 1'b1;
      node_waddr = SW'(1);
      node_wdata = '0;
    end else if (cmd.new_t) begin
      node_we    = 1'b1;
      node_waddr = cnt_inc;
      node_wdata = {SW'(0), rd_len + SW'(1)};
    end else if (cmd.clone_row) begin
      node_we    = 1'b1;
      node_waddr = nq_r;
      node_wdata = {linkq_r, lenp_r + SW'(1)};
    end else if (cmd.clone_fix) begin
      node_we    = 1'b1;
      node_waddr = q_r;
      node_wdata = {nq_r, lenq_r};
    end else if (cmd.out_done) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    rd_row <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    rd_node <= node_mem[node_raddr];
  end

  // Walk registers (payload, no reset needed).
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sym_r <= in_sym;
      p_r   <= last_r;
      nq_r  <= '0;
    end
    if (cmd.step_link) begin
      p_r <= rd_link;
    end
    if (cmd.take_q) begin
      q_r    <= entry;
      lenp_r <= rd_len;
    end
    if (cmd.new_t) begin
      t_r    <= cnt_inc;
      lent_r <= rd_len + SW'(1);
      p_r    <= last_r;
    end
    if (cmd.set_lk_q) begin
      lk_r <= q_r;
    end
    if (cmd.lk_root) begin
      lk_r <= SW'(1);
    end
    if (cmd.alloc_nq) begin
      nq_r    <= cnt_inc;
      linkq_r <= rd_link;
      lenq_r  <= rd_len;
    end
    if (cmd.clone_fix) begin
      lk_r <= nq_r;
    end
  end

  // Last state and allocation count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= SW'(1);
      cnt_r  <= SW'(1);
    end else begin
      if (cmd.new_t) begin
        last_r <= cnt_inc;
        cnt_r  <= cnt_inc;
      end else if (cmd.alloc_nq) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_bad || cmd.out_ovf || cmd.out_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_bad || cmd.out_ovf) begin
      o_ns_r  <= '0;
      o_len_r <= '0;
      o_lk_r  <= '0;
      o_cl_r  <= 1'b0;
      o_cs_r  <= '0;
      o_ov_r  <= cmd.out_ovf;
    end else if (cmd.out_done) begin
      o_ns_r  <= t_r;
      o_len_r <= lent_r;
      o_lk_r  <= lk_r;
      o_cl_r  <= (nq_r != '0);
      o_cs_r  <= nq_r;
      o_ov_r  <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_state     = o_ns_r;
  assign out_prefix_length = o_len_r;
  assign out_new_link      = o_lk_r;
  assign out_cloned        = o_cl_r;
  assign out_clone_state   = o_cs_r;
  assign out_overflow      = o_ov_r;

endmodule
